>>> rtl/core/skf_pkg.sv
// Shared types and constants of the scalar Kalman filter.
package skf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = GAIN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COVARIANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE      = 2'd3;

  localparam logic [DATA_W-1:0] RST_INIT_ESTIMATE   = 32'h0000_0000;
  localparam logic [DATA_W-1:0] RST_INIT_COVARIANCE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RST_PROCESS_NOISE   = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RST_MEAS_NOISE      = 32'h0002_0000;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a transaction, reload state on restart
    logic predict;   // covariance predict, denominator, divider seed
    logic div_step;  // one quotient bit of the gain division
    logic multiply;  // register both update products
    logic update;    // commit state and result registers
  } skf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current division step is the final one
  } skf_status_t;

endpackage

>>> rtl/core/skf_ctrl.sv
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  skf_pkg::skf_status_t status,
  output skf_pkg::skf_cmd_t    cmd
);
  import skf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREDICT,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:     cmd.load     = in_valid;
      ST_PREDICT:  cmd.predict  = 1'b1;
      ST_DIVIDE:   cmd.div_step = 1'b1;
      ST_MULTIPLY: cmd.multiply = 1'b1;
      ST_FINISH:   cmd.update   = out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken; in ST_FINISH a new one replaces it below
      if (out_valid && !out_stall && state != ST_FINISH) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_PREDICT;
        end
        ST_PREDICT:  state <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (status.div_last) state <= ST_MULTIPLY;
        end
        ST_MULTIPLY: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/skf_datapath.sv
// Registers, divider and multipliers of the scalar Kalman filter.
module skf_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  skf_pkg::skf_cmd_t                    cmd,
  output skf_pkg::skf_status_t                 status,
  input  logic                                 cfg_write,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]           cfg_data,
  input  logic signed [skf_pkg::DATA_W-1:0]    sample,
  input  logic                                 restart,
  output logic signed [skf_pkg::DATA_W-1:0]    new_estimate,
  output logic [skf_pkg::DATA_W-1:0]           new_covariance,
  output logic [skf_pkg::GAIN_W-1:0]           gain,
  output logic                                 saturated
);
  import skf_pkg::*;

  // configuration
  logic signed [DATA_W-1:0] init_estimate;
  logic [DATA_W-1:0]        init_covariance;
  logic [DATA_W-1:0]        process_noise;
  logic [DATA_W-1:0]        meas_noise;

  // filter state
  logic signed [DATA_W-1:0] estimate;
  logic [DATA_W-1:0]        covariance;

  // per-transaction working registers
  logic signed [DATA_W-1:0] z;
  logic [DATA_W-1:0]        p;
  logic                     sat_p;
  logic [DATA_W:0]          den;
  logic [DATA_W:0]          rem;
  logic [GAIN_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]     count;
  logic [GAIN_W-1:0]        gain_used;
  logic signed [GAIN_W+DATA_W+1:0] prod_e;
  logic [GAIN_W+DATA_W-1:0]        prod_c;

  // predict
  logic [DATA_W:0]   p_sum;
  logic [DATA_W-1:0] p_next;
  assign p_sum  = {1'b0, covariance} + {1'b0, process_noise};
  assign p_next = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

  // divide: numerator is p << 16, seeded with p >> 1 so 17 bits remain
  logic [DATA_W+1:0] r_shift;
  logic [DATA_W+1:0] r_diff;
  logic              r_ge;
  assign r_shift = {rem, (count == '0) ? p[0] : 1'b0};
  assign r_diff  = r_shift - {1'b0, den};
  assign r_ge    = (r_shift >= {1'b0, den});
  assign status.div_last = (count == DIV_CNT_W'(DIV_STEPS - 1));

  // multiply operands
  logic [GAIN_W-1:0]        g_sel;
  logic signed [DATA_W:0]   innov;
  logic [GAIN_W-1:0]        one_minus_g;
  assign g_sel       = (den == '0) ? '0 : quo;
  assign innov       = {z[DATA_W-1], z} - {estimate[DATA_W-1], estimate};
  assign one_minus_g = ONE_Q16 - g_sel;

  // update: floor shift by 16, then clamp to signed 32 bits
  logic signed [DATA_W+2:0] delta;
  logic signed [DATA_W+2:0] e_sum;
  logic signed [DATA_W-1:0] e_clamp;
  logic                     e_sat;
  assign delta = prod_e[GAIN_W+DATA_W+1:16];
  assign e_sum = {{3{estimate[DATA_W-1]}}, estimate} + delta;
  always_comb begin
    e_sat   = 1'b0;
    e_clamp = e_sum[DATA_W-1:0];
    if (e_sum > 35'sh0_7FFF_FFFF) begin
      e_sat   = 1'b1;
      e_clamp = 32'sh7FFF_FFFF;
    end else if (e_sum < -35'sh0_8000_0000) begin
      e_sat   = 1'b1;
      e_clamp = 32'sh8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_estimate   <= RST_INIT_ESTIMATE;
      init_covariance <= RST_INIT_COVARIANCE;
      process_noise   <= RST_PROCESS_NOISE;
      meas_noise      <= RST_MEAS_NOISE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INIT_ESTIMATE:   init_estimate   <= cfg_data;
        REG_INIT_COVARIANCE: init_covariance <= cfg_data;
        REG_PROCESS_NOISE:   process_noise   <= cfg_data;
        REG_MEAS_NOISE:      meas_noise      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate   <= '0;
      covariance <= RST_INIT_COVARIANCE;
    end else if (cmd.load && restart) begin
      estimate   <= init_estimate;
      covariance <= init_covariance;
    end else if (cmd.update) begin
      estimate   <= e_clamp;
      covariance <= prod_c[DATA_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) z <= sample;
    if (cmd.predict) begin
      p     <= p_next;
      sat_p <= p_sum[DATA_W];
      den   <= {1'b0, p_next} + {1'b0, meas_noise};
      rem   <= {2'b00, p_next[DATA_W-1:1]};
      count <= '0;
    end
    if (cmd.div_step) begin
      rem   <= r_ge ? r_diff[DATA_W:0] : r_shift[DATA_W:0];
      quo   <= {quo[GAIN_W-2:0], r_ge};
      count <= count + 1'b1;
    end
    if (cmd.multiply) begin
      gain_used <= g_sel;
      prod_e    <= $signed({1'b0, g_sel}) * innov;
      prod_c    <= (GAIN_W+DATA_W)'(one_minus_g) * (GAIN_W+DATA_W)'(p);
    end
    if (cmd.update) begin
      new_estimate   <= e_clamp;
      new_covariance <= prod_c[DATA_W+15:16];
      gain           <= gain_used;
      saturated      <= sat_p | e_sat;
    end
  end

endmodule

>>> rtl/core/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: controller plus datapath.
//
// One-dimensional Kalman filter. Each input transaction (a signed Q16.16
// sample and a restart bit) runs a predict step, P = min(P + Q, max), and an
// update step: gain = floor(P * 65536 / (P + R)) as unsigned Q1.16 (zero when
// P + R is zero), estimate += floor(gain * (sample - estimate) / 65536) with
// clamping, and P = floor((1 - gain) * P). A set restart bit first reloads
// estimate and covariance from the initial-value registers. Each input gives
// exactly one output transaction: new estimate, new covariance, gain and a
// saturation flag. From acceptance to the result register a transaction
// passes the predict state, the divide state of the restoring gain divider
// (one quotient bit per cycle, 17 quotient bits), the multiply state and the
// commit state. No new input is taken until that commit is done and the block
// is back in the idle state that accepts the next input. in_stall is high
// while a transaction is in flight. A finished result waits in the output
// register while the next input is accepted; the commit of that next one
// waits until the previous result is taken. Configuration registers (index 0
// initial estimate, 1 initial covariance, 2 process noise, 3 measurement
// noise) are written through cfg_write/cfg_index/cfg_data and must only
// change while the block is idle.
module scalar_kalman_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [skf_pkg::DATA_W-1:0]  sample,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [skf_pkg::DATA_W-1:0]  new_estimate,
  output logic [skf_pkg::DATA_W-1:0]         new_covariance,
  output logic [skf_pkg::GAIN_W-1:0]         gain,
  output logic                               saturated
);
  import skf_pkg::*;

  skf_cmd_t    cmd;
  skf_status_t status;

  // sequence the predict, divide, multiply and commit steps
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // hold configuration, filter state and the result register
  skf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .restart        (restart),
    .new_estimate   (new_estimate),
    .new_covariance (new_covariance),
    .gain           (gain),
    .saturated      (saturated)
  );

endmodule

>>> rtl/core/skf_checker.sv
// Port-level assertions of the scalar Kalman filter, bound to the top level.
module skf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [skf_pkg::DATA_W-1:0]         new_estimate,
  input logic [skf_pkg::DATA_W-1:0]         new_covariance,
  input logic [skf_pkg::GAIN_W-1:0]         gain
);
  import skf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(new_estimate) &&
                                  $stable(new_covariance) && $stable(gain)))
    else $error("stalled result changed");

  // one transaction at a time: accepting blocks the next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while busy");

  // no result can appear the cycle after an acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain <= ONE_Q16))
    else $error("gain above one");

  // unit gain leaves no covariance
  a_unit_gain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gain == ONE_Q16) |-> (new_covariance == '0))
    else $error("covariance not cleared at unit gain");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .new_estimate   (new_estimate),
  .new_covariance (new_covariance),
  .gain           (gain)
);
